### hdl/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// Shared constants and types of the escaped frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

    // Payload buffer size in bytes
    localparam int MAX_FRAME = 64;
    localparam int ADDR_W    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);

    // Register reset values
    localparam logic [7:0] ESCAPE_RESET = 8'h48;
    localparam logic [7:0] START_RESET  = 8'h11;

    // Register indexes on the configuration port
    localparam logic REG_ESCAPE = 1'b0;
    localparam logic REG_START  = 1'b1;

    // Frame close command from the parser to the readout
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } drain_cmd_t;

    // One result word
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       empty_frame;
        logic       truncated;
    } result_t;

endpackage

`default_nettype wire

### hdl/efd_ram.sv
// ----------------------------------------------------------------------------
// efd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/efd_parse.sv
// ----------------------------------------------------------------------------
// efd_parse
// Byte parser: hunts for escape/start, buffers payload into the store and
// issues a close command with the frame length on a closing escape/start.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_parse (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [7:0]                  data_byte,
    input  wire logic [7:0]                  escape_value,
    input  wire logic [7:0]                  start_value,
    output logic                             wr_en,
    output logic [efd_pkg::ADDR_W-1:0]       wr_addr,
    output logic [7:0]                       wr_data,
    output efd_pkg::drain_cmd_t              cmd
);

    logic                      inside_reg,  inside_next;
    logic                      pend_reg,    pend_next;
    logic                      hunt_reg,    hunt_next;
    logic [efd_pkg::LEN_W-1:0] len_reg,     len_next;
    logic                      ovf_reg,     ovf_next;
    logic                      store;
    logic                      is_esc;
    logic                      is_start;

    assign is_esc   = (data_byte == escape_value);
    assign is_start = (data_byte == start_value);

    // Decide the next parser state for an accepted byte
    always_comb
    begin
        inside_next = inside_reg;
        pend_next   = pend_reg;
        hunt_next   = hunt_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        store       = 1'b0;
        cmd         = '0;
        if (accept)
        begin
            if (inside_reg)
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (is_start)
                    begin
                        cmd.start   = 1'b1;
                        cmd.len     = len_reg;
                        cmd.ovf     = ovf_reg;
                        len_next    = '0;
                        ovf_next    = 1'b0;
                        inside_next = 1'b0;
                    end
                    else if (!is_esc)
                    begin
                        len_next    = '0;
                        ovf_next    = 1'b0;
                        inside_next = 1'b0;
                    end
                    else
                    begin
                        store = 1'b1;
                    end
                end
                else if (is_esc)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    store = 1'b1;
                end
            end
            else if (!hunt_reg && is_esc)
            begin
                hunt_next = 1'b1;
            end
            else if (hunt_reg && is_start)
            begin
                hunt_next   = 1'b0;
                inside_next = 1'b1;
                pend_next   = 1'b0;
                len_next    = '0;
                ovf_next    = 1'b0;
            end
            else
            begin
                hunt_next = 1'b0;
            end

            // Buffer the byte, or drop it and flag the frame when full
            if (store)
            begin
                if (len_reg < efd_pkg::LEN_W'(efd_pkg::MAX_FRAME))
                begin
                    len_next = len_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    assign wr_en   = store && (len_reg < efd_pkg::LEN_W'(efd_pkg::MAX_FRAME));
    assign wr_addr = len_reg[efd_pkg::ADDR_W-1:0];
    assign wr_data = data_byte;

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            pend_reg   <= 1'b0;
            hunt_reg   <= 1'b0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            inside_reg <= inside_next;
            pend_reg   <= pend_next;
            hunt_reg   <= hunt_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

`default_nettype wire

### hdl/efd_drain.sv
// ----------------------------------------------------------------------------
// efd_drain
// Frame readout: walks the store one read per cycle when a slot is free and
// delivers result words via an output register backed by a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_drain (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire efd_pkg::drain_cmd_t         cmd,
    output logic                             busy,
    output logic                             rd_en,
    output logic [efd_pkg::ADDR_W-1:0]       rd_addr,
    input  wire logic [7:0]                  rd_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output efd_pkg::result_t                 out_word
);

    logic                      busy_reg,     busy_next;
    logic [efd_pkg::LEN_W-1:0] cnt_reg,      cnt_next;
    logic [efd_pkg::LEN_W-1:0] idx_reg,      idx_next;
    logic                      empty_reg,    empty_next;
    logic                      ovf_reg,      ovf_next;
    logic                      rd_pend_reg;
    logic                      rd_last_reg;
    logic                      out_v_reg,    out_v_next;
    logic                      skid_v_reg,   skid_v_next;
    efd_pkg::result_t          out_reg,      out_next;
    efd_pkg::result_t          skid_reg,     skid_next;
    efd_pkg::result_t          landing;
    logic                      pop;
    logic                      out_free;
    logic [1:0]                occ;
    logic                      issue;
    logic                      done;

    assign pop      = out_v_reg && out_ready;
    assign out_free = !out_v_reg || pop;
    assign occ      = 2'(out_v_reg) + 2'(skid_v_reg) + 2'(rd_pend_reg) - 2'(pop);

    // Issue a read while words remain and a slot is sure to be free
    assign issue   = busy_reg && (cnt_reg != '0) && (occ <= 2'd1);
    assign rd_en   = issue && !empty_reg;
    assign rd_addr = idx_reg[efd_pkg::ADDR_W-1:0];

    // Word returning from the store this cycle
    always_comb
    begin
        landing.frame_byte  = empty_reg ? 8'h00 : rd_data;
        landing.last_byte   = rd_last_reg;
        landing.empty_frame = empty_reg;
        landing.truncated   = ovf_reg;
    end

    // Load a new frame or advance the read pointer
    always_comb
    begin
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        empty_next = empty_reg;
        ovf_next   = ovf_reg;
        if (cmd.start)
        begin
            empty_next = (cmd.len == '0);
            cnt_next   = (cmd.len == '0) ? efd_pkg::LEN_W'(1) : cmd.len;
            idx_next   = '0;
            ovf_next   = cmd.ovf;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg - 1'b1;
            idx_next = idx_reg + 1'b1;
        end
    end

    // Steer returning words into the output or skid register
    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        out_next    = out_reg;
        skid_next   = skid_reg;
        if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_v_next  = 1'b1;
                out_next    = skid_reg;
                skid_v_next = rd_pend_reg;
                skid_next   = landing;
            end
            else
            begin
                out_v_next = rd_pend_reg;
                out_next   = landing;
            end
        end
        else if (rd_pend_reg)
        begin
            skid_v_next = 1'b1;
            skid_next   = landing;
        end
    end

    // Finish once every word has been taken
    assign done      = (cnt_reg == '0) && !rd_pend_reg && !skid_v_reg && out_free;
    assign busy_next = cmd.start || (busy_reg && !done);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            out_v_reg   <= 1'b0;
            skid_v_reg  <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= issue;
            out_v_reg   <= out_v_next;
            skid_v_reg  <= skid_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        empty_reg   <= empty_next;
        ovf_reg     <= ovf_next;
        rd_last_reg <= (cnt_reg == efd_pkg::LEN_W'(1));
        out_reg     <= out_next;
        skid_reg    <= skid_next;
    end

    assign busy      = busy_reg;
    assign out_valid = out_v_reg;
    assign out_word  = out_reg;

endmodule

`default_nettype wire

### hdl/escaped_frame_deframer.sv
// A closing escape/start pair starts readout through the store and output registers.
// Throughput: one input byte per cycle while no frame is being read out.
// Readout: one result word per cycle unless m_tready stalls, from the store's single
//   read port; input is held off from the closing byte until the last word is taken.
// Reset: parser and readout control clear, escape reads 0x48 and start 0x11;
//   the payload store is not cleared and is written before it is read.
// ----------------------------------------------------------------------------
// escaped_frame_deframer
// Escape byte-stuffing deframer with a 64-byte payload store and APB setup.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] frame_byte
    output logic             m_tlast,   // last_byte
    output logic [1:0]       m_tuser,   // [0] empty_frame, [1] truncated
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]                 escape_reg;
    logic [7:0]                 start_reg;
    logic                       cfg_wr;
    logic                       accept;
    logic                       busy;
    logic                       wr_en;
    logic [efd_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                 wr_data;
    logic                       rd_en;
    logic [efd_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                 rd_data;
    efd_pkg::drain_cmd_t        cmd;
    efd_pkg::result_t           out_word;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= efd_pkg::ESCAPE_RESET;
            start_reg  <= efd_pkg::START_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == efd_pkg::REG_ESCAPE)
            begin
                escape_reg <= pwdata[7:0];
            end
            else
            begin
                start_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == efd_pkg::REG_START) ? {24'h0, start_reg}
                                                     : {24'h0, escape_reg};

    // Hold off input while a frame is read out
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    efd_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_tdata),
        .escape_value (escape_reg),
        .start_value  (start_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .cmd          (cmd)
    );

    // Payload store; writes and reads never overlap since input stalls during readout
    efd_ram #(
        .WIDTH (8),
        .DEPTH (efd_pkg::MAX_FRAME)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    efd_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = out_word.frame_byte;
    assign m_tlast = out_word.last_byte;
    assign m_tuser = {out_word.truncated, out_word.empty_frame};

endmodule

`default_nettype wire

### hdl/efd_checker.sv
// ----------------------------------------------------------------------------
// efd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // No input is taken while a frame is being delivered
    a_no_input_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready during readout");

    // An empty frame is a single zero word, marked last and not truncated
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 8'h00) && !m_tuser[1])
        else $error("malformed empty frame word");

    // After a non-last word is taken, input stays held off for its frame
    a_trunc_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("frame readout ended before last word");

endmodule

bind escaped_frame_deframer efd_checker u_efd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### bench/escaped_frame_deframer_test.sv
// ----------------------------------------------------------------------------
// escaped_frame_deframer_test
// Self-checking bench for the escape byte-stuffing deframer. A table of
// directed bytes and then random frames, aborts and noise are streamed in
// under several escape/start settings and idle patterns. Each accepted byte
// runs through a local deframer predictor, and every result word is compared
// field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_deframer_test;

    typedef enum int {
        IDLE_NONE,
        IDLE_TX,
        IDLE_RX,
        IDLE_BOTH
    } idle_mode_t;

    // One directed byte with an optional hand-written result word
    typedef struct packed {
        logic [7:0]       data;
        logic             known;
        efd_pkg::result_t word;
    } stim_row_t;

    localparam logic [7:0] E = efd_pkg::ESCAPE_RESET;
    localparam logic [7:0] S = efd_pkg::START_RESET;

    localparam efd_pkg::result_t NO_WORD    = '0;
    localparam efd_pkg::result_t EMPTY_WORD = '{8'h00, 1'b1, 1'b1, 1'b0};
    localparam efd_pkg::result_t TOP_WORD   = '{8'hFF, 1'b1, 1'b0, 1'b0};

    localparam stim_row_t DIRECTED_ROWS [24] = '{
        // open and close at once: empty frame
        '{E, 1'b0, NO_WORD}, '{S, 1'b0, NO_WORD},
        '{E, 1'b0, NO_WORD}, '{S, 1'b1, EMPTY_WORD},
        // second escape while hunting cancels the hunt
        '{E, 1'b0, NO_WORD}, '{E, 1'b0, NO_WORD}, '{S, 1'b0, NO_WORD},
        // single top byte
        '{E, 1'b0, NO_WORD}, '{S, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
        '{E, 1'b0, NO_WORD}, '{S, 1'b1, TOP_WORD},
        // zero byte and a stuffed escape
        '{E, 1'b0, NO_WORD}, '{S, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{E, 1'b0, NO_WORD}, '{E, 1'b0, NO_WORD},
        '{E, 1'b0, NO_WORD}, '{S, 1'b0, NO_WORD},
        // start byte as payload, then abort
        '{E, 1'b0, NO_WORD}, '{S, 1'b0, NO_WORD}, '{S, 1'b0, NO_WORD},
        '{E, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] frame_byte
    logic        m_tlast;          // last_byte
    logic [1:0]  m_tuser;          // [0] empty_frame, [1] truncated
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Side band that travels with each input word
    logic             row_known = 1'b0;
    efd_pkg::result_t row_word = '0;

    // Predictor state and register copies
    logic [7:0] escape_cfg = efd_pkg::ESCAPE_RESET;
    logic [7:0] start_cfg  = efd_pkg::START_RESET;
    bit         in_frame;
    bit         esc_seen;
    bit         hunting;
    logic [7:0] frame_buf [efd_pkg::MAX_FRAME];
    int         frame_len;
    bit         frame_lost;

    efd_pkg::result_t frame_words_due [$];
    int      mismatches = 0;
    int      sent = 0;
    int      tx_gap_pct = 0;
    int      rx_hold_pct = 0;

    escaped_frame_deframer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Buffer one payload byte, drop it once the store is full
    function automatic void keep_byte(input logic [7:0] b);
        if (frame_len < efd_pkg::MAX_FRAME)
        begin
            frame_buf[frame_len] = b;
            frame_len++;
        end
        else
            frame_lost = 1'b1;
    endfunction

    function automatic void drop_frame();
        frame_len  = 0;
        frame_lost = 1'b0;
        in_frame   = 1'b0;
    endfunction

    // Advance the deframer by one byte and queue the words it releases
    function automatic void deframe_byte(input logic [7:0] b);
        efd_pkg::result_t word;
        if (in_frame)
        begin
            if (esc_seen)
            begin
                esc_seen = 1'b0;
                if (b == start_cfg)
                begin
                    if (frame_len == 0)
                        frame_words_due.push_back(EMPTY_WORD);
                    else
                        for (int i = 0; i < frame_len; i++)
                        begin
                            word.frame_byte  = frame_buf[i];
                            word.last_byte   = (i == frame_len - 1);
                            word.empty_frame = 1'b0;
                            word.truncated   = frame_lost;
                            frame_words_due.push_back(word);
                        end
                    drop_frame();
                end
                else if (b != escape_cfg)
                    drop_frame();
                else
                    keep_byte(b);
            end
            else if (b == escape_cfg)
                esc_seen = 1'b1;
            else
                keep_byte(b);
        end
        else if (!hunting && b == escape_cfg)
            hunting = 1'b1;
        else if (hunting && b == start_cfg)
        begin
            hunting    = 1'b0;
            in_frame   = 1'b1;
            esc_seen   = 1'b0;
            frame_len  = 0;
            frame_lost = 1'b0;
        end
        else
            hunting = 1'b0;
    endfunction

    // Predict on every accepted input word
    always @(posedge clk)
    begin
        int n0;
        if (rst_n && s_tvalid && s_tready)
        begin
            n0 = frame_words_due.size();
            deframe_byte(s_tdata);
            if (row_known)
            begin
                while (frame_words_due.size() > n0)
                    void'(frame_words_due.pop_back());
                frame_words_due.push_back(row_word);
            end
        end
    end

    // Check every accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        efd_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: byte %02h last %b user %02b",
                             m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = frame_words_due.pop_front();
                if (m_tdata !== want.frame_byte || m_tlast !== want.last_byte ||
                    m_tuser[0] !== want.empty_frame || m_tuser[1] !== want.truncated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("expected byte/last/empty/trunc %02h/%b/%b/%b got %02h/%b/%b/%b",
                                 want.frame_byte, want.last_byte, want.empty_frame,
                                 want.truncated, m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                end
            end
        end
    end

    // Stall the result stream at the current rate
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_hold_pct);

    function automatic void set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_TX:   begin tx_gap_pct = 74; rx_hold_pct = 0;  end
            IDLE_RX:   begin tx_gap_pct = 0;  rx_hold_pct = 74; end
            IDLE_BOTH: begin tx_gap_pct = 29; rx_hold_pct = 29; end
            default:   begin tx_gap_pct = 0;  rx_hold_pct = 0;  end
        endcase
    endfunction

    // Offer one word, with random gaps ahead of it, and hold until taken
    task automatic send_byte(input logic [7:0] b, input logic known = 1'b0,
                             input efd_pkg::result_t word = '0);
        while ($urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        row_known <= known;
        row_word  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (frame_words_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == efd_pkg::REG_ESCAPE)
            escape_cfg = value;
        else
            start_cfg = value;
    endtask

    // Well-formed frame with escapes stuffed in the payload
    task automatic send_frame(input int len);
        logic [7:0] b;
        send_byte(escape_cfg);
        send_byte(start_cfg);
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == escape_cfg)
                send_byte(b);
            send_byte(b);
        end
        send_byte(escape_cfg);
        send_byte(start_cfg);
    endtask

    task automatic run_random(input int budget, input idle_mode_t first,
                              input bit full_frame, input bit drain_midway);
        int         base;
        int         pick;
        logic [7:0] b;
        base = sent;
        set_idle(first);
        if (full_frame)
            send_frame(66);
        while (sent < base + budget)
        begin
            set_idle(idle_mode_t'((int'(first) + (sent - base) / 32) % 4));
            if (drain_midway && sent >= base + budget / 2)
            begin
                settle();
                drain_midway = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 72)
                send_frame(($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                                       : $urandom_range(0, 8));
            else if (pick < 82)
            begin
                // open, a few bytes, then escape and a plain byte
                send_byte(escape_cfg);
                send_byte(start_cfg);
                repeat ($urandom_range(0, 4))
                    send_byte(8'($urandom_range(0, 255)));
                send_byte(escape_cfg);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == escape_cfg || b == start_cfg);
                send_byte(b);
            end
            else if (pick < 92)
                send_byte(8'($urandom_range(0, 255)));
            else
            begin
                // broken opening pair
                send_byte(escape_cfg);
                send_byte(($urandom_range(0, 1) == 1) ? escape_cfg : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        logic [7:0] v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset settings
        set_idle(IDLE_NONE);
        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].word);
        run_random(95, IDLE_TX, 1'b1, 1'b1);

        settle();
        write_reg(efd_pkg::REG_ESCAPE, 8'h00);
        write_reg(efd_pkg::REG_START, 8'hFF);
        run_random(95, IDLE_RX, 1'b0, 1'b0);

        settle();
        write_reg(efd_pkg::REG_ESCAPE, 8'hFF);
        write_reg(efd_pkg::REG_START, 8'h00);
        run_random(95, IDLE_BOTH, 1'b0, 1'b0);

        // escape equal to start
        settle();
        write_reg(efd_pkg::REG_ESCAPE, 8'h7E);
        write_reg(efd_pkg::REG_START, 8'h7E);
        run_random(95, IDLE_NONE, 1'b0, 1'b0);

        settle();
        v = 8'($urandom_range(0, 255));
        write_reg(efd_pkg::REG_ESCAPE, v);
        write_reg(efd_pkg::REG_START, v ^ 8'($urandom_range(1, 255)));
        run_random(95, IDLE_TX, 1'b0, 1'b0);

        settle();
        if (mismatches == 0)
            $display("escaped_frame_deframer: match");
        else
            $display("escaped_frame_deframer: mismatch");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #800000;
        $display("escaped_frame_deframer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hdl/efd_pkg.sv
hdl/efd_ram.sv
hdl/efd_parse.sv
hdl/efd_drain.sv
hdl/escaped_frame_deframer.sv
hdl/efd_checker.sv
bench/escaped_frame_deframer_test.sv
